/* rtl/ts_pid_demux_channel_monitor_assert.svh */
// assertion macros shared by the checker of the pid demux channel monitor
// no dependencies; include by bare file name
`ifndef TS_PID_DEMUX_CHANNEL_MONITOR_ASSERT_SVH
`define TS_PID_DEMUX_CHANNEL_MONITOR_ASSERT_SVH

// clocked check, off while reset is held
`define TSPDCM_ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tspdcm check failed");

// clocked check that also runs through reset
`define TSPDCM_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("tspdcm reset check failed");

`endif

/* rtl/tspdcm_pkg.sv */
// types and constants of the pid demux channel monitor
// no dependencies; used by the cell and the top level
package tspdcm_pkg;

    // item modes
    typedef enum logic [1:0] {
        MODE_PACKET = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_TABLE  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // control states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    // configuration register indexes
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_LIVE_THRESH   = 2'd1;
    localparam logic [1:0] REG_IDLE_TIMEOUT  = 2'd2;
    localparam logic [1:0] REG_PKT_PER_DGRAM = 2'd3;

    // shared pids and limits
    localparam logic [12:0] PID_PAT   = 13'd0;
    localparam logic [12:0] PID_EIT   = 13'd18;
    localparam logic [15:0] COUNT_MAX = 16'hffff;
    localparam int          MASK_W    = 8;

    // configuration seen by every cell
    typedef struct packed {
        logic [3:0]  channel_count;
        logic [15:0] live_threshold;
        logic [8:0]  pkt_per_dgram;
    } t_cfg;

    // item and partial result handed from cell to cell
    typedef struct packed {
        logic              go;
        t_mode             mode;
        logic [12:0]       pid;
        logic [2:0]        tch;
        logic [2:0]        tslot;
        logic              tvalid;
        logic              any_up;
        logic [MASK_W-1:0] dest;
        logic [MASK_W-1:0] flush;
        logic [MASK_W-1:0] up;
    } t_link;

endpackage

/* rtl/tspdcm_cell.sv */
// one channel cell: pid slots, packet count, buffer fill and up flag
// depends on tspdcm_pkg; chained by the top level
module tspdcm_cell
    import tspdcm_pkg::*;
#(
    parameter int SLOTS = 8,
    parameter int IDX   = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_link i_link,
    output t_link o_link
);

    localparam bit         IN_MASK = (IDX < MASK_W);
    localparam logic [2:0] BIT_POS = 3'(IDX % MASK_W);

    logic [12:0]      r_slot_pid [SLOTS];
    logic [12:0]      n_slot_pid [SLOTS];
    logic [SLOTS-1:0] r_slot_ok, n_slot_ok;
    logic [15:0]      r_count, n_count;
    logic [8:0]       r_fill, n_fill;
    logic             r_up, n_up;
    logic             r_go;
    t_link            r_link, n_link;

    logic       w_active;
    logic       w_hit;
    logic       w_shared;
    logic       w_route;
    logic [8:0] w_limit;
    logic [8:0] w_fill_inc;

    // slot match, one comparator per slot
    always_comb begin
        w_hit = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            if (r_slot_ok[s] && (r_slot_pid[s] == i_link.pid)) begin
                w_hit = 1'b1;
            end
        end
    end

    assign w_active   = (int'(i_cfg.channel_count) > IDX);
    assign w_shared   = (i_link.pid == PID_PAT) || (i_link.pid == PID_EIT);
    assign w_route    = i_link.go && (i_link.mode == MODE_PACKET) && w_active
                        && (w_shared || w_hit);
    assign w_limit    = (i_cfg.pkt_per_dgram == 9'd0) ? 9'd1 : i_cfg.pkt_per_dgram;
    assign w_fill_inc = r_fill + 9'd1;

    // channel state update and partial result
    always_comb begin
        n_slot_pid = r_slot_pid;
        n_slot_ok  = r_slot_ok;
        n_count    = r_count;
        n_fill     = r_fill;
        n_up       = r_up;
        n_link     = i_link;

        // packet routing, counting and datagram fill
        if (w_route) begin
            if (!w_shared && (r_count != COUNT_MAX)) begin
                n_count = r_count + 16'd1;
            end
            if (IN_MASK) begin
                n_link.dest[BIT_POS] = 1'b1;
            end
            if (w_fill_inc >= w_limit) begin
                n_fill = 9'd0;
                if (IN_MASK) begin
                    n_link.flush[BIT_POS] = 1'b1;
                end
            end else begin
                n_fill = w_fill_inc;
            end
        end

        // tick: judge liveness, restart the interval count
        if (i_link.go && (i_link.mode == MODE_TICK)) begin
            if (w_active) begin
                n_up = (r_count >= i_cfg.live_threshold);
            end
            n_count = 16'd0;
        end

        // table write into this channel's slots
        if (i_link.go && (i_link.mode == MODE_TABLE) && (int'(i_link.tch) == IDX)) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (int'(i_link.tslot) == s) begin
                    n_slot_pid[s] = i_link.pid;
                    n_slot_ok[s]  = i_link.tvalid;
                end
            end
        end

        // liveness summary for the rest of the chain
        if (i_link.go && (i_link.mode == MODE_TICK) && w_active && n_up) begin
            n_link.any_up = 1'b1;
        end
        if (IN_MASK) begin
            n_link.up[BIT_POS] = w_active && n_up;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ok <= '0;
            r_count   <= 16'd0;
            r_fill    <= 9'd0;
            r_up      <= 1'b1;
            r_go      <= 1'b0;
        end else begin
            r_slot_ok <= n_slot_ok;
            r_count   <= n_count;
            r_fill    <= n_fill;
            r_up      <= n_up;
            r_go      <= n_link.go;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_slot_pid <= n_slot_pid;
        r_link     <= n_link;
    end

    always_comb begin
        o_link    = r_link;
        o_link.go = r_go;
    end

endmodule

/* rtl/ts_pid_demux_channel_monitor.sv */
// top level of the transport stream pid demux with channel liveness monitor
// depends on tspdcm_pkg and tspdcm_cell
//
// usage: items enter on i_in_valid / o_in_ready with a mode: packet header
// (route by pid), timer tick (liveness and stop), or table write (load a
// pid slot). every item gives one result on o_out_valid / i_out_ready:
// destination mask, flush mask, up mask and the sticky stop flag.
// the item walks a row of CHANNELS cells, one cell per cycle; each cell
// owns one channel's slots and counters and adds its bit to the masks.
// the block takes no new item until the last has walked the whole cell row
// and its result has left the holding register. a new item is taken while
// a finished result still waits at the output; when the receiver stalls,
// the next result waits in a holding register and the block takes no
// further item until the output frees. reset: all slots invalid, counts
// and fills zero, every channel up, stop clear, configuration at its
// defaults. configuration writes on i_cfg_we take effect at once; the user
// makes them only while the block is idle, the block does not enforce it.
module ts_pid_demux_channel_monitor
    import tspdcm_pkg::*;
#(
    parameter int CHANNELS          = 8,
    parameter int SLOTS_PER_CHANNEL = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [12:0] i_packet_pid,
    input  logic [31:0] i_now_seconds,
    input  logic [2:0]  i_table_channel,
    input  logic [2:0]  i_table_slot,
    input  logic        i_table_valid,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_dest_mask,
    output logic [7:0]  o_flush_mask,
    output logic [7:0]  o_up_mask,
    output logic        o_stop
);

    t_state r_state, n_state;
    t_cfg   r_cfg;
    logic [15:0] r_timeout;
    t_link  r_cmd;
    t_link  r_res;
    logic [31:0] r_now;
    logic   r_go;
    logic   r_out_valid;
    logic [7:0] r_dest, r_flush, r_up;
    logic   r_stop, n_stop;
    logic   r_idle_valid, n_idle_valid;
    logic [31:0] r_idle_since, n_idle_since;
    logic [31:0] w_elapsed;
    logic   w_accept;
    logic   w_release;
    t_link  w_link [CHANNELS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count  <= 4'd0;
            r_cfg.live_threshold <= 16'd100;
            r_timeout            <= 16'd600;
            r_cfg.pkt_per_dgram  <= 9'd7;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CHANNEL_COUNT: r_cfg.channel_count  <= i_cfg_data[3:0];
                REG_LIVE_THRESH:   r_cfg.live_threshold <= i_cfg_data;
                REG_IDLE_TIMEOUT:  r_timeout            <= i_cfg_data;
                REG_PKT_PER_DGRAM: r_cfg.pkt_per_dgram  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid)            n_state = ST_RUN;
            ST_RUN:  if (w_link[CHANNELS].go)   n_state = ST_HOLD;
            ST_HOLD: if (w_release)             n_state = ST_IDLE;
            default:                            n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_release  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_RUN:  ;
            ST_HOLD: w_release  = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // head of the cell chain
    always_comb begin
        w_link[0]        = r_cmd;
        w_link[0].go     = r_go;
        w_link[0].any_up = 1'b0;
        w_link[0].dest   = '0;
        w_link[0].flush  = '0;
        w_link[0].up     = '0;
    end

    // row of channel cells
    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        tspdcm_cell #(
            .SLOTS (SLOTS_PER_CHANNEL),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    // idle tracking and stop latch, applied as a tick result leaves
    assign w_elapsed = r_now - r_idle_since;

    always_comb begin
        n_idle_valid = r_idle_valid;
        n_idle_since = r_idle_since;
        n_stop       = r_stop;
        if (w_release && (r_res.mode == MODE_TICK)) begin
            if (r_res.any_up) begin
                n_idle_valid = 1'b0;
                n_idle_since = 32'd0;
            end else if (!r_idle_valid) begin
                n_idle_valid = 1'b1;
                n_idle_since = r_now;
            end else if (w_elapsed > {16'd0, r_timeout}) begin
                n_stop = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_go         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_stop       <= 1'b0;
            r_idle_valid <= 1'b0;
            r_idle_since <= 32'd0;
        end else begin
            r_state      <= n_state;
            r_go         <= w_accept;
            r_stop       <= n_stop;
            r_idle_valid <= n_idle_valid;
            r_idle_since <= n_idle_since;
            if (w_release) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture, chain tail capture and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.go     <= 1'b0;
            r_cmd.mode   <= t_mode'(i_mode);
            r_cmd.pid    <= i_packet_pid;
            r_cmd.tch    <= i_table_channel;
            r_cmd.tslot  <= i_table_slot;
            r_cmd.tvalid <= i_table_valid;
            r_cmd.any_up <= 1'b0;
            r_cmd.dest   <= '0;
            r_cmd.flush  <= '0;
            r_cmd.up     <= '0;
            r_now        <= i_now_seconds;
        end
        if ((r_state == ST_RUN) && w_link[CHANNELS].go) begin
            r_res <= w_link[CHANNELS];
        end
        if (w_release) begin
            r_dest  <= r_res.dest;
            r_flush <= r_res.flush;
            r_up    <= r_res.up;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_dest_mask  = r_dest;
    assign o_flush_mask = r_flush;
    assign o_up_mask    = r_up;
    assign o_stop       = r_stop;

endmodule

/* rtl/tspdcm_checker.sv */
// port-level checks of the pid demux channel monitor, bound to the top level
// depends on ts_pid_demux_channel_monitor_assert.svh
`include "ts_pid_demux_channel_monitor_assert.svh"

module tspdcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic [7:0]  o_dest_mask,
    input logic [7:0]  o_flush_mask,
    input logic        o_stop
);

    // stop never falls outside reset
    `TSPDCM_ASSERT_CLK(a_stop_sticky, o_stop |=> o_stop)

    // one item in flight: an accept closes the input for the next cycle
    `TSPDCM_ASSERT_CLK(a_one_in_flight, (i_in_valid && o_in_ready) |=> !o_in_ready)

    // a channel only flushes on a packet routed to it
    `TSPDCM_ASSERT_CLK(a_flush_in_dest, o_out_valid |-> ((o_flush_mask & ~o_dest_mask) == 8'd0))

    // a fresh result comes with the input open again
    `TSPDCM_ASSERT_CLK(a_result_frees_input, $rose(o_out_valid) |-> o_in_ready)

    // reset clears the output and the stop latch
    `TSPDCM_ASSERT_RST(a_reset_clear, !i_rst_n |=> (!o_out_valid && !o_stop))

endmodule

bind ts_pid_demux_channel_monitor tspdcm_checker u_tspdcm_checker (.*);
